// ----- hdl/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

    // Width of the line phase and acknowledge timers.
    localparam int TIMER_W = 16;

    // Command codes carried by the operation field.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // One classified tick, as queued between the front and the sequencer.
    typedef struct packed {
        logic       cmd_ok;
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // One result item.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } res_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic advance;
        logic busy;
    } seq_status_t;

endpackage

`default_nettype wire

// ----- hdl/i2cm_front.sv -----
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       cmd_valid,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] write_data,
    input  wire logic       send_ack,
    input  wire logic       sda_in,
    output logic            q_valid,
    output tick_t           q_item,
    input  wire logic       q_pop
);

    tick_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;
    tick_t      item_in;

    // Classify the tick: only a legal operation counts as a command.
    always_comb
    begin
        item_in.cmd_ok     = cmd_valid && (operation <= OP_WAIT);
        item_in.operation  = operation;
        item_in.write_data = write_data;
        item_in.send_ack   = send_ack;
        item_in.sda_in     = sda_in;
    end

    assign full    = (count_reg == 2'd2);
    assign wr_en   = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign rd_en   = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    // Occupancy of the two-entry queue.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_seq.sv -----
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [TIMER_W-1:0] cfg_data,
    input  wire logic               in_valid,
    input  wire tick_t              in_item,
    output logic                    in_pop,
    input  wire logic               res_ready,
    output logic                    res_push,
    output res_t                    res_item,
    output seq_status_t             status
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_1    = 3'd1;
    localparam logic [2:0] PH_2    = 3'd2;
    localparam logic [2:0] PH_3    = 3'd3;
    localparam logic [2:0] PH_4    = 3'd4;
    localparam logic [2:0] PH_5    = 3'd5;
    localparam logic [2:0] PH_6    = 3'd6;
    localparam logic [2:0] PH_7    = 3'd7;

    logic [TIMER_W-1:0] half_reg;
    logic [TIMER_W-1:0] timeout_reg;

    logic [2:0]         phase_reg,  phase_next;
    logic [2:0]         op_reg,     op_next;
    logic [3:0]         bit_reg,    bit_next;
    logic [7:0]         shift_reg,  shift_next;
    logic [TIMER_W-1:0] ptimer_reg, ptimer_next;
    logic [TIMER_W-1:0] atimer_reg, atimer_next;
    logic               choice_reg, choice_next;
    logic               scl_reg,    scl_next;
    logic               sda_reg,    sda_next;
    logic [7:0]         rx_reg,     rx_next;
    logic               fail_reg,   fail_next;

    logic               advance;
    logic               done;
    logic               do_enter;
    logic               write_end;
    logic [2:0]         step;
    logic [TIMER_W-1:0] hold;
    logic [TIMER_W-1:0] ptimer_dec;
    logic [3:0]         bit_inc;

    // Line levels {scl, sda} set on entry to a step of a command.
    function automatic logic [1:0] enter_lines(
        input logic [2:0] op,
        input logic [2:0] st,
        input logic       choice,
        input logic       msb,
        input logic       scl,
        input logic       sda
    );
        logic       a;
        logic [1:0] lv;
        a = !choice;
        unique case (op)
            OP_START:
            begin
                if (st == PH_1)      lv = 2'b11;
                else if (st == PH_2) lv = 2'b10;
                else                 lv = 2'b00;
            end
            OP_STOP:
            begin
                if (st == PH_1)      lv = {scl, 1'b0};
                else if (st == PH_2) lv = 2'b10;
                else                 lv = 2'b11;
            end
            OP_WRITE:
            begin
                lv = {st != PH_1, msb};
            end
            OP_READ:
            begin
                if (st == PH_1)      lv = {1'b1, sda};
                else if (st == PH_2) lv = {1'b0, sda};
                else if (st == PH_3) lv = {1'b0, a};
                else if (st == PH_4) lv = {1'b1, a};
                else if (st == PH_5) lv = {1'b0, a};
                else                 lv = 2'b01;
            end
            default:
            begin
                if (st == PH_1)                     lv = {scl, 1'b1};
                else if (st == PH_2 || st == PH_3)  lv = 2'b11;
                else if (st == PH_4)                lv = {scl, 1'b0};
                else if (st == PH_5)                lv = 2'b10;
                else if (st == PH_6)                lv = 2'b11;
                else                                lv = {1'b0, sda};
            end
        endcase
        return lv;
    endfunction

    // One tick is consumed whenever it is queued and the result has room.
    assign advance  = in_valid && res_ready;
    assign in_pop   = advance;
    assign res_push = advance;

    assign hold       = (half_reg == '0) ? {{(TIMER_W-1){1'b0}}, 1'b1} : half_reg;
    assign ptimer_dec = (ptimer_reg != '0) ? ptimer_reg - TIMER_W'(1) : ptimer_reg;
    assign bit_inc    = bit_reg + 4'd1;

    // Step sequencer: decide the next step and the line levels for this tick.
    always_comb
    begin
        phase_next  = phase_reg;
        op_next     = op_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        ptimer_next = ptimer_reg;
        atimer_next = atimer_reg;
        choice_next = choice_reg;
        rx_next     = rx_reg;
        fail_next   = fail_reg;
        done        = 1'b0;
        do_enter    = 1'b0;
        write_end   = 1'b0;
        step        = PH_IDLE;

        if (advance)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (in_item.cmd_ok)
                begin
                    op_next     = in_item.operation;
                    bit_next    = 4'd0;
                    shift_next  = (in_item.operation == OP_WRITE) ? in_item.write_data : 8'd0;
                    choice_next = in_item.send_ack;
                    if (in_item.operation == OP_WAIT)
                    begin
                        fail_next = 1'b0;
                    end
                    do_enter = 1'b1;
                    step     = PH_1;
                end
            end
            else if (op_reg == OP_WAIT && phase_reg == PH_3)
            begin
                // Poll SDA with SCL high until the slave pulls it low or the acknowledge timeout runs out.
                if (!in_item.sda_in)
                begin
                    do_enter = 1'b1;
                    step     = PH_7;
                end
                else if (atimer_reg >= timeout_reg)
                begin
                    fail_next = 1'b1;
                    do_enter  = 1'b1;
                    step      = PH_4;
                end
                else
                begin
                    atimer_next = atimer_reg + TIMER_W'(1);
                end
            end
            else
            begin
                ptimer_next = ptimer_dec;
                if (ptimer_dec == '0)
                begin
                    unique case (op_reg)
                        OP_START, OP_STOP:
                        begin
                            if (phase_reg >= PH_3)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                do_enter = 1'b1;
                                step     = phase_reg + 3'd1;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (phase_reg == PH_1)
                            begin
                                do_enter = 1'b1;
                                step     = PH_2;
                            end
                            else
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bit_next   = bit_inc;
                                if (bit_inc >= 4'd8)
                                begin
                                    write_end = 1'b1;
                                    done      = 1'b1;
                                end
                                else
                                begin
                                    do_enter = 1'b1;
                                    step     = PH_1;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (phase_reg == PH_1)
                            begin
                                shift_next = {shift_reg[6:0], in_item.sda_in};
                                do_enter   = 1'b1;
                                step       = PH_2;
                            end
                            else if (phase_reg == PH_2)
                            begin
                                bit_next = bit_inc;
                                do_enter = 1'b1;
                                if (bit_inc >= 4'd8)
                                begin
                                    rx_next = shift_reg;
                                    step    = PH_3;
                                end
                                else
                                begin
                                    step = PH_1;
                                end
                            end
                            else if (phase_reg == PH_5)
                            begin
                                if (!choice_reg)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    do_enter = 1'b1;
                                    step     = PH_6;
                                end
                            end
                            else if (phase_reg >= PH_6)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                do_enter = 1'b1;
                                step     = phase_reg + 3'd1;
                            end
                        end
                        default:
                        begin
                            if (phase_reg >= PH_7)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                do_enter = 1'b1;
                                step     = phase_reg + 3'd1;
                            end
                        end
                    endcase
                end
            end
        end

        // Step entry, write completion and command completion.
        {scl_next, sda_next} = {scl_reg, sda_reg};
        if (do_enter)
        begin
            phase_next  = step;
            ptimer_next = hold;
            {scl_next, sda_next} = enter_lines(op_next, step, choice_next,
                                               shift_next[7], scl_reg, sda_reg);
            if (op_next == OP_WAIT && step == PH_3)
            begin
                atimer_next = '0;
            end
        end
        if (write_end)
        begin
            {scl_next, sda_next} = 2'b01;
        end
        if (done)
        begin
            phase_next  = PH_IDLE;
            ptimer_next = '0;
        end
    end

    // Result of this tick, taken after the update.
    always_comb
    begin
        res_item.scl_out    = scl_next;
        res_item.sda_out    = sda_next;
        res_item.busy_res   = (phase_next != PH_IDLE);
        res_item.done_res   = done;
        res_item.read_data  = rx_next;
        res_item.ack_failed = fail_next;
    end

    assign status.advance = advance;
    assign status.busy    = (phase_reg != PH_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= TIMER_W'(2);
            timeout_reg <= TIMER_W'(250);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_HALF_PERIOD: half_reg    <= cfg_data;
                CFG_ACK_TIMEOUT: timeout_reg <= cfg_data;
                default:         half_reg    <= half_reg;
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            op_reg     <= OP_START;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            ptimer_reg <= '0;
            atimer_reg <= '0;
            choice_reg <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            rx_reg     <= 8'd0;
            fail_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            ptimer_reg <= ptimer_next;
            atimer_reg <= atimer_next;
            choice_reg <= choice_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            rx_reg     <= rx_next;
            fail_reg   <= fail_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_outq.sv -----
`default_nettype none

module i2cm_outq
    import i2cm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  wire res_t res_item,
    output logic      res_ready,
    output logic      empty,
    input  wire logic pop,
    output res_t      head
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;

    // A full queue still takes an item in the cycle its head is taken.
    assign empty     = (count_reg == 2'd0);
    assign rd_en     = pop && !empty;
    assign res_ready = (count_reg != 2'd2) || rd_en;
    assign wr_en     = res_push && res_ready;
    assign head      = mem_reg[rd_ptr_reg];

    // Occupancy of the result queue.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2c_master_bit_engine.sv -----
// A tick is held in the tick queue and its result in the result queue before it reaches the ports.
// Throughput: one tick per clock while neither queue stalls; the step sequencer updates once per tick.
// A two-entry tick queue and a two-entry result queue let either side stall alone.
// Reset (rst_n low, asynchronous) empties both queues, idles the sequencer, releases
// both lines high and loads the half period with 2 and the acknowledge timeout with 250.
`default_nettype none

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [TIMER_W-1:0] cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               cmd_valid,
    input  wire logic [2:0]         operation,
    input  wire logic [7:0]         write_data,
    input  wire logic               send_ack,
    input  wire logic               sda_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    scl_out,
    output logic                    sda_out,
    output logic                    busy_res,
    output logic                    done_res,
    output logic [7:0]              read_data,
    output logic                    ack_failed
);

    logic        q_valid;
    tick_t       q_item;
    logic        q_pop;
    logic        res_ready;
    logic        res_push;
    res_t        res_item;
    res_t        head;
    seq_status_t status;

    // Front: accepts and classifies ticks.
    i2cm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_valid  (cmd_valid),
        .operation  (operation),
        .write_data (write_data),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back: line step sequencer.
    i2cm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_pop    (q_pop),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res_item  (res_item),
        .status    (status)
    );

    // Result queue towards the consumer.
    i2cm_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_ready (res_ready),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign scl_out    = head.scl_out;
    assign sda_out    = head.sda_out;
    assign busy_res   = head.busy_res;
    assign done_res   = head.done_res;
    assign read_data  = head.read_data;
    assign ack_failed = head.ack_failed;

`ifndef SYNTHESIS
    // A completing command always leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_item.done_res |-> !res_item.busy_res)
        else $error("done item still shows busy");

    // Without a consumed tick the sequencer cannot change its busy state.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !status.advance |=> $stable(status.busy))
        else $error("sequencer moved while stalled");

    // A result is only produced when a queued tick is consumed.
    a_push_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> q_valid && q_pop && res_ready)
        else $error("result pushed without a tick");

    // A pending result is visible on the ports in the next cycle.
    a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("result queue empty after push");
`endif

endmodule

`default_nettype wire

// ----- tb/i2c_master_bit_engine_tb.sv -----
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    // One tick as offered on the input side.
    typedef struct {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } tick_item_t;

    // One row of the directed table: a tick, how often it repeats, and an
    // optional expected line state typed in by hand.
    typedef struct {
        tick_item_t tick;
        int         reps;
        bit         typed;
        res_t       want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_addr;
    logic [TIMER_W-1:0] cfg_data;
    logic               push;
    logic               full;
    logic               cmd_valid;
    logic [2:0]         operation;
    logic [7:0]         write_data;
    logic               send_ack;
    logic               sda_in;
    logic               empty;
    logic               pop;
    logic               scl_out;
    logic               sda_out;
    logic               busy_res;
    logic               done_res;
    logic [7:0]         read_data;
    logic               ack_failed;

    i2c_master_bit_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .cmd_valid  (cmd_valid),
        .operation  (operation),
        .write_data (write_data),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .empty      (empty),
        .pop        (pop),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_data  (read_data),
        .ack_failed (ack_failed)
    );

    // Line engine mirror: configuration and sequencer state.
    logic [15:0] half_cfg;
    logic [15:0] tmo_cfg;
    logic [3:0]  st_phase;
    logic [2:0]  st_op;
    logic [3:0]  st_bits;
    logic [7:0]  st_shift;
    logic [15:0] st_timer;
    logic [15:0] st_ack_cnt;
    logic        st_ack_sel;
    logic        st_scl;
    logic        st_sda;
    logic [7:0]  st_rx;
    logic        st_fail;

    // Expected line states, oldest first.
    res_t        line_state_q[$];
    logic [2:0]  bus_script_q[$];
    dir_row_t    dir_rows[$];

    int errors;
    bit no_gaps;
    bit hold_req;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= 40)
        begin
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
        end
    endtask

    // Enter a line step: load the hold timer and set both lines.
    function automatic void enter_step(input logic [3:0] step);
        logic ack_bit;
        ack_bit  = ~st_ack_sel;
        st_phase = step;
        st_timer = (half_cfg == 16'd0) ? 16'd1 : half_cfg;
        case (st_op)
            OP_START:
            begin
                st_scl = (step != 4'd3);
                st_sda = (step == 4'd1);
            end
            OP_STOP:
            begin
                if (step == 4'd1)
                begin
                    st_sda = 1'b0;
                end
                else
                begin
                    st_scl = 1'b1;
                    st_sda = (step != 4'd2);
                end
            end
            OP_WRITE:
            begin
                st_scl = (step != 4'd1);
                st_sda = st_shift[7];
            end
            OP_READ:
            begin
                case (step)
                    4'd1: st_scl = 1'b1;
                    4'd2: st_scl = 1'b0;
                    4'd3, 4'd5:
                    begin
                        st_scl = 1'b0;
                        st_sda = ack_bit;
                    end
                    4'd4:
                    begin
                        st_scl = 1'b1;
                        st_sda = ack_bit;
                    end
                    default:
                    begin
                        st_scl = 1'b0;
                        st_sda = 1'b1;
                    end
                endcase
            end
            default:
            begin
                case (step)
                    4'd1: st_sda = 1'b1;
                    4'd2, 4'd3, 4'd6:
                    begin
                        st_scl = 1'b1;
                        st_sda = 1'b1;
                    end
                    4'd4: st_sda = 1'b0;
                    4'd5:
                    begin
                        st_scl = 1'b1;
                        st_sda = 1'b0;
                    end
                    default: st_scl = 1'b0;
                endcase
                if (step == 4'd3)
                begin
                    st_ack_cnt = 16'd0;
                end
            end
        endcase
    endfunction

    // The current step's hold has run out; returns 1 when the command is complete.
    function automatic logic expire_step(input logic sda);
        case (st_op)
            OP_START, OP_STOP:
            begin
                if (st_phase >= 4'd3)
                begin
                    return 1'b1;
                end
                enter_step(st_phase + 4'd1);
                return 1'b0;
            end
            OP_WRITE:
            begin
                if (st_phase == 4'd1)
                begin
                    enter_step(4'd2);
                    return 1'b0;
                end
                st_shift = {st_shift[6:0], 1'b0};
                st_bits  = st_bits + 4'd1;
                if (st_bits >= 4'd8)
                begin
                    st_scl = 1'b0;
                    st_sda = 1'b1;
                    return 1'b1;
                end
                enter_step(4'd1);
                return 1'b0;
            end
            OP_READ:
            begin
                if (st_phase == 4'd1)
                begin
                    st_shift = {st_shift[6:0], sda};
                    enter_step(4'd2);
                    return 1'b0;
                end
                if (st_phase == 4'd2)
                begin
                    st_bits = st_bits + 4'd1;
                    if (st_bits >= 4'd8)
                    begin
                        st_rx = st_shift;
                        enter_step(4'd3);
                    end
                    else
                    begin
                        enter_step(4'd1);
                    end
                    return 1'b0;
                end
                if (st_phase == 4'd5)
                begin
                    if (!st_ack_sel)
                    begin
                        return 1'b1;
                    end
                    enter_step(4'd6);
                    return 1'b0;
                end
                if (st_phase >= 4'd6)
                begin
                    return 1'b1;
                end
                enter_step(st_phase + 4'd1);
                return 1'b0;
            end
            default:
            begin
                if (st_phase >= 4'd7)
                begin
                    return 1'b1;
                end
                enter_step(st_phase + 4'd1);
                return 1'b0;
            end
        endcase
    endfunction

    // Advance the mirror by one tick and return the line state it leads to.
    function automatic res_t predict_tick(input tick_item_t t);
        res_t r;
        logic done;
        done = 1'b0;
        if (st_phase == 4'd0)
        begin
            if (t.cmd_valid && t.operation <= OP_WAIT)
            begin
                st_op      = t.operation;
                st_bits    = 4'd0;
                st_shift   = (t.operation == OP_WRITE) ? t.write_data : 8'd0;
                st_ack_sel = t.send_ack;
                if (t.operation == OP_WAIT)
                begin
                    st_fail = 1'b0;
                end
                enter_step(4'd1);
            end
        end
        else if (st_op == OP_WAIT && st_phase == 4'd3)
        begin
            // Polling for the acknowledge with SCL held high.
            if (!t.sda_in)
            begin
                enter_step(4'd7);
            end
            else if (st_ack_cnt >= tmo_cfg)
            begin
                st_fail = 1'b1;
                enter_step(4'd4);
            end
            else
            begin
                st_ack_cnt = st_ack_cnt + 16'd1;
            end
        end
        else
        begin
            if (st_timer > 16'd0)
            begin
                st_timer = st_timer - 16'd1;
            end
            if (st_timer == 16'd0)
            begin
                done = expire_step(t.sda_in);
                if (done)
                begin
                    st_phase = 4'd0;
                    st_timer = 16'd0;
                end
            end
        end
        r.scl_out    = st_scl;
        r.sda_out    = st_sda;
        r.busy_res   = (st_phase != 4'd0);
        r.done_res   = done;
        r.read_data  = st_rx;
        r.ack_failed = st_fail;
        return r;
    endfunction

    // Offer one tick after a random gap and hold it until it is taken.
    task automatic push_tick(input tick_item_t t, input bit typed, input res_t want);
        int   gap;
        res_t pred;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        cmd_valid  <= t.cmd_valid;
        operation  <= t.operation;
        write_data <= t.write_data;
        send_ack   <= t.send_ack;
        sda_in     <= t.sda_in;
        do @(posedge clk); while (full);
        pred = predict_tick(t);
        line_state_q.push_back(typed ? want : pred);
    endtask

    // Let every pending line state drain, then write both registers.
    task automatic set_config(input logic [15:0] half_val, input logic [15:0] tmo_val);
        push <= 1'b0;
        while (line_state_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_HALF_PERIOD;
        cfg_data <= half_val;
        @(posedge clk);
        cfg_addr <= CFG_ACK_TIMEOUT;
        cfg_data <= tmo_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        half_cfg = half_val;
        tmo_cfg  = tmo_val;
    endtask

    // Run plain ticks with SDA low until the sequencer is idle again.
    task automatic settle_engine();
        tick_item_t t;
        res_t       unused;
        t.cmd_valid  = 1'b0;
        t.operation  = OP_START;
        t.write_data = 8'd0;
        t.send_ack   = 1'b0;
        t.sda_in     = 1'b0;
        unused       = '0;
        while (st_phase != 4'd0)
        begin
            push_tick(t, 1'b0, unused);
        end
    endtask

    // Draw the next random tick, mostly following well-formed bus transactions.
    task automatic next_random_tick(output tick_item_t t);
        int n;
        t.cmd_valid  = 1'b0;
        t.operation  = 3'($urandom_range(0, 7));
        t.write_data = 8'($urandom);
        t.send_ack   = 1'($urandom);
        t.sda_in     = 1'($urandom);
        if (st_phase == 4'd0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Stray command, possibly an unknown code.
                t.cmd_valid = 1'b1;
            end
            else if ($urandom_range(0, 4) != 0)
            begin
                if (bus_script_q.size() == 0)
                begin
                    bus_script_q.push_back(OP_START);
                    bus_script_q.push_back(OP_WRITE);
                    bus_script_q.push_back(OP_WAIT);
                    n = $urandom_range(0, 2);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            bus_script_q.push_back(OP_WRITE);
                            bus_script_q.push_back(OP_WAIT);
                        end
                        else
                        begin
                            bus_script_q.push_back(OP_READ);
                        end
                    end
                    bus_script_q.push_back(OP_STOP);
                end
                t.cmd_valid = 1'b1;
                t.operation = bus_script_q.pop_front();
            end
        end
        else
        begin
            // Commands while busy are noise; acknowledges come now and then.
            t.cmd_valid = ($urandom_range(0, 9) == 0);
            if (st_op == OP_WAIT && st_phase == 4'd3)
            begin
                t.sda_in = ($urandom_range(0, 3) != 0);
            end
        end
    endtask

    function automatic void add_row(input logic v, input logic [2:0] op, input logic [7:0] wd,
                                    input logic sack, input logic sda, input int reps,
                                    input bit typed, input res_t want);
        dir_row_t row;
        row.tick.cmd_valid  = v;
        row.tick.operation  = op;
        row.tick.write_data = wd;
        row.tick.send_ack   = sack;
        row.tick.sda_in     = sda;
        row.reps            = reps;
        row.typed           = typed;
        row.want            = want;
        dir_rows.push_back(row);
    endfunction

    // Result side: random stalls, one long hold on request, check every item.
    initial
    begin
        int   stall;
        res_t got;
        res_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = 40;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.scl_out    = scl_out;
            got.sda_out    = sda_out;
            got.busy_res   = busy_res;
            got.done_res   = done_res;
            got.read_data  = read_data;
            got.ack_failed = ack_failed;
            if (line_state_q.size() == 0)
            begin
                report_mismatch("unexpected item", 32'(got), 0);
            end
            else
            begin
                want = line_state_q.pop_front();
                if (got.scl_out !== want.scl_out)
                    report_mismatch("scl_out", got.scl_out, want.scl_out);
                if (got.sda_out !== want.sda_out)
                    report_mismatch("sda_out", got.sda_out, want.sda_out);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", got.done_res, want.done_res);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", got.ack_failed, want.ack_failed);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain and verdict.
    initial
    begin
        res_t        idle_lines;
        res_t        none;
        tick_item_t  t;
        logic [15:0] half_list[6];
        logic [15:0] tmo_list[6];

        errors   = 0;
        no_gaps  = 1'b0;
        hold_req = 1'b0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_addr   <= CFG_HALF_PERIOD;
        cfg_data   <= '0;
        push       <= 1'b0;
        pop        <= 1'b0;
        cmd_valid  <= 1'b0;
        operation  <= OP_START;
        write_data <= 8'd0;
        send_ack   <= 1'b0;
        sda_in     <= 1'b1;

        // Mirror starts from the reset state.
        half_cfg   = 16'd2;
        tmo_cfg    = 16'd250;
        st_phase   = 4'd0;
        st_op      = OP_START;
        st_bits    = 4'd0;
        st_shift   = 8'd0;
        st_timer   = 16'd0;
        st_ack_cnt = 16'd0;
        st_ack_sel = 1'b0;
        st_scl     = 1'b1;
        st_sda     = 1'b1;
        st_rx      = 8'd0;
        st_fail    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        idle_lines         = '0;
        idle_lines.scl_out = 1'b1;
        idle_lines.sda_out = 1'b1;
        none               = '0;

        // Directed table, run with the reset configuration.
        // Idle after reset, and unknown codes that leave the engine idle.
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 3, 1'b1, idle_lines);
        add_row(1'b1, 3'd5, 8'hA5, 1'b1, 1'b1, 1, 1'b1, idle_lines);
        add_row(1'b1, 3'd7, 8'h5A, 1'b0, 1'b0, 1, 1'b1, idle_lines);
        add_row(1'b1, 3'd6, 8'h00, 1'b1, 1'b0, 1, 1'b1, idle_lines);
        // Start condition.
        add_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 7, 1'b0, none);
        // Write of all ones, then an acknowledge after a few high polls.
        add_row(1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b1, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 34, 1'b0, none);
        add_row(1'b1, OP_WAIT, 8'h00, 1'b0, 1'b1, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 6, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 4, 1'b0, none);
        // Write of all zeros, then an immediate acknowledge.
        add_row(1'b1, OP_WRITE, 8'h00, 1'b0, 1'b0, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 34, 1'b0, none);
        add_row(1'b1, OP_WAIT, 8'h00, 1'b0, 1'b0, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 10, 1'b0, none);
        // Read ending with ACK, then read ending with NACK.
        add_row(1'b1, OP_READ, 8'h00, 1'b1, 1'b1, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 18, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 24, 1'b0, none);
        add_row(1'b1, OP_READ, 8'h00, 1'b0, 1'b0, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 40, 1'b0, none);
        // Stop; commands while busy and on the completion tick are ignored, then a start is taken once idle.
        add_row(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b0, none);
        add_row(1'b1, OP_WRITE, 8'h3C, 1'b0, 1'b1, 5, 1'b0, none);
        add_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 2, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 7, 1'b0, none);
        // Acknowledge timeout with stop, then a good acknowledge clears the flag.
        add_row(1'b1, OP_WAIT, 8'h00, 1'b0, 1'b1, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 270, 1'b0, none);
        add_row(1'b1, OP_WAIT, 8'h00, 1'b0, 1'b0, 1, 1'b0, none);
        add_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 10, 1'b0, none);

        foreach (dir_rows[i])
        begin
            repeat (dir_rows[i].reps)
            begin
                push_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
            end
        end
        settle_engine();

        // Random phases, each with its own timing; zero values included.
        half_list = '{16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'd1};
        tmo_list  = '{16'd2, 16'd0, 16'd3, 16'd1, 16'd6, 16'd20};
        for (int p = 0; p < 6; p++)
        begin
            set_config(half_list[p], tmo_list[p]);
            no_gaps  = (p % 3 == 2);
            hold_req = (p == 1 || p == 4);
            repeat (20)
            begin
                next_random_tick(t);
                push_tick(t, 1'b0, none);
            end
            settle_engine();
        end

        // Largest register values, with only ignored codes offered.
        set_config(16'hFFFF, 16'hFFFF);
        no_gaps = 1'b0;
        repeat (20)
        begin
            t.cmd_valid  = 1'($urandom);
            t.operation  = 3'($urandom_range(5, 7));
            t.write_data = 8'($urandom);
            t.send_ack   = 1'($urandom);
            t.sda_in     = 1'($urandom);
            push_tick(t, 1'b0, none);
        end

        // Drain and look for stray items.
        push <= 1'b0;
        while (line_state_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
